### design/tnga_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnga_pkg
// Shared types and constants of the tree node gravity accumulator.
// ----------------------------------------------------------------------------
package tnga_pkg;

  localparam int REG_W     = 32;   // theta, G, softening, mass
  localparam int SIDE_W    = 31;
  localparam int KIND_W    = 2;
  localparam int CFG_IDX_W = 3;
  localparam int ROOT_W    = 64;   // saturated radius sum and its root
  localparam int DEN_W     = 2 * ROOT_W;
  localparam int FM_W      = 2 * REG_W;
  localparam int LHS_SHIFT = 16;
  localparam int NUM_SHIFT = 56;
  localparam int AXES      = 3;

  localparam logic [REG_W-1:0] THETA_RST = 32'd16384;
  localparam logic [REG_W-1:0] GRAV_RST  = 32'd65536;
  localparam logic [REG_W-1:0] SOFT_RST  = 32'd655;

  localparam logic [1:0] LAST_AXIS = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THETA = 3'd0,
    REG_GRAV  = 3'd1,
    REG_SOFT  = 3'd2,
    REG_PX    = 3'd3,
    REG_PY    = 3'd4,
    REG_PZ    = 3'd5,
    REG_SELF  = 3'd6
  } cfg_reg_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_INTERNAL = 2'd0,
    KIND_UNUSED   = 2'd1,
    KIND_EXTERNAL = 2'd2
  } node_kind_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQ_GO,
    ST_SQ_WAIT,
    ST_KIND,
    ST_LHS_GO,
    ST_LHS_WAIT,
    ST_RHS_GO,
    ST_RHS_WAIT,
    ST_RSUM,
    ST_ROOT_GO,
    ST_ROOT_WAIT,
    ST_DEN_GO,
    ST_DEN_WAIT,
    ST_FM_GO,
    ST_FM_WAIT,
    ST_NUM_GO,
    ST_NUM_WAIT,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_OUT
  } tnga_state_e;

endpackage

### design/tnga_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnga channel interfaces
// Node input, result output and register write channels.
// ----------------------------------------------------------------------------
interface tnga_node_if #(
  parameter int COORD_BITS = 32,
  parameter int INDEX_BITS = 16
);
  logic                                 valid;
  logic                                 ready;
  logic                                 start_walk;
  logic [tnga_pkg::KIND_W-1:0]          node_kind;
  logic [INDEX_BITS-1:0]                node_particle;
  logic [tnga_pkg::REG_W-1:0]           node_mass;
  logic signed [COORD_BITS-1:0]         centre_x;
  logic signed [COORD_BITS-1:0]         centre_y;
  logic signed [COORD_BITS-1:0]         centre_z;
  logic [tnga_pkg::SIDE_W-1:0]          node_side;

  modport source (output valid, start_walk, node_kind, node_particle, node_mass,
                  centre_x, centre_y, centre_z, node_side, input ready);
  modport sink   (input valid, start_walk, node_kind, node_particle, node_mass,
                  centre_x, centre_y, centre_z, node_side, output ready);
endinterface

interface tnga_res_if #(
  parameter int ACC_BITS = 48
);
  logic                       valid;
  logic                       ready;
  logic                       descend;
  logic signed [ACC_BITS-1:0] sum_acc_x;
  logic signed [ACC_BITS-1:0] sum_acc_y;
  logic signed [ACC_BITS-1:0] sum_acc_z;

  modport source (output valid, descend, sum_acc_x, sum_acc_y, sum_acc_z, input ready);
  modport sink   (input valid, descend, sum_acc_x, sum_acc_y, sum_acc_z, output ready);
endinterface

interface tnga_cfg_if #(
  parameter int DATA_W = 32
);
  logic                             valid;
  logic                             ready;
  logic [tnga_pkg::CFG_IDX_W-1:0]   index;
  logic [DATA_W-1:0]                data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### design/tnga_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnga_mul
// Shift-add multiplier, one multiplier bit per cycle, stops early on zero.
// ----------------------------------------------------------------------------
module tnga_mul #(
  parameter int A_W = 64,
  parameter int B_W = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [A_W-1:0]     a_i,
  input  logic [B_W-1:0]     b_i,
  output logic               done_o,
  output logic [A_W+B_W-1:0] prod_o
);

  localparam int P_W = A_W + B_W;

  logic           busy_q;
  logic [P_W-1:0] a_q;
  logic [B_W-1:0] b_q;
  logic [P_W-1:0] p_q;

  assign done_o = busy_q && (b_q == '0);
  assign prod_o = p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (done_o) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= P_W'(a_i);
      b_q <= b_i;
      p_q <= '0;
    end else if (busy_q && (b_q != '0)) begin
      if (b_q[0]) begin
        p_q <= p_q + a_q;
      end
      a_q <= {a_q[P_W-2:0], 1'b0};
      b_q <= {1'b0, b_q[B_W-1:1]};
    end
  end

endmodule

### design/tnga_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnga_sqrt
// Bit-serial integer root of r * 2^64, one root bit per cycle.
// ----------------------------------------------------------------------------
module tnga_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [tnga_pkg::ROOT_W-1:0] r_i,
  output logic                        done_o,
  output logic [tnga_pkg::ROOT_W-1:0] root_o
);

  localparam int RW    = tnga_pkg::ROOT_W;
  localparam int REM_W = RW + 2;
  localparam int CNT_W = $clog2(RW);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [RW-1:0]    x_q;
  logic [RW-1:0]    root_q;
  logic [REM_W-1:0] rem_q;
  logic [REM_W+1:0] rem_sh;
  logic [REM_W+1:0] trial;
  logic             ge;

  assign rem_sh = {rem_q, x_q[RW-1:RW-2]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign ge     = rem_sh >= trial;
  assign done_o = done_q;
  assign root_o = root_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && (cnt_q == '0)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= r_i;
      rem_q  <= '0;
      root_q <= '0;
      cnt_q  <= CNT_W'(RW - 1);
    end else if (busy_q) begin
      rem_q  <= ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
      root_q <= {root_q[RW-2:0], ge};
      x_q    <= {x_q[RW-3:0], 2'b00};
      cnt_q  <= cnt_q - 1'b1;
    end
  end

endmodule

### design/tnga_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnga_div
// Restoring divider, one quotient bit per cycle, saturates the quotient.
// ----------------------------------------------------------------------------
module tnga_div #(
  parameter int NUM_W = 153,
  parameter int DEN_W = 128,
  parameter int Q_W   = 47
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [Q_W-1:0]   quot_o
);

  localparam int TOP_W = NUM_W - Q_W;
  localparam int RW    = (TOP_W > DEN_W) ? TOP_W : DEN_W;
  localparam int CNT_W = $clog2(Q_W + 1);

  logic             busy_q;
  logic             chk_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [RW-1:0]    rem_q;
  logic [Q_W-1:0]   nlow_q;
  logic [DEN_W-1:0] den_q;
  logic [Q_W-1:0]   quot_q;
  logic             sat;
  logic [RW:0]      rem_sh;
  logic             ge;
  logic             last;

  // quotient would not fit below the top bit
  assign sat    = rem_q >= RW'(den_q);
  assign rem_sh = {rem_q, nlow_q[Q_W-1]};
  assign ge     = rem_sh >= (RW + 1)'(den_q);
  assign last   = busy_q && (chk_q ? sat : (cnt_q == CNT_W'(1)));
  assign done_o = done_q;
  assign quot_o = quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      chk_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= last;
      if (start_i) begin
        busy_q <= 1'b1;
        chk_q  <= 1'b1;
      end else begin
        if (last) begin
          busy_q <= 1'b0;
        end
        if (busy_q) begin
          chk_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= RW'(num_i[NUM_W-1:Q_W]);
      nlow_q <= num_i[Q_W-1:0];
      den_q  <= den_i;
      quot_q <= '0;
      cnt_q  <= CNT_W'(Q_W);
    end else if (busy_q) begin
      if (chk_q) begin
        if (sat) begin
          quot_q <= '1;
        end
      end else begin
        rem_q  <= ge ? RW'(rem_sh - (RW + 1)'(den_q)) : RW'(rem_sh);
        quot_q <= {quot_q[Q_W-2:0], ge};
        nlow_q <= {nlow_q[Q_W-2:0], 1'b0};
        cnt_q  <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### design/tree_node_gravity_accumulate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tree_node_gravity_accumulate
// Barnes-Hut node handler: opening test and softened gravity accumulation.
// ----------------------------------------------------------------------------
// unused or self nodes only square the offsets; contributing nodes also use
// the one shared shift-add multiplier (one bit per cycle, stops when the
// multiplier runs out of ones) and the bit-serial root, with the numerator
// multiply and the divider run once per axis
// throughput: one item at a time; the next item is taken while a result waits
// reset: registers to their reset values, accumulators zero, nothing in flight
module tree_node_gravity_accumulate #(
  parameter int COORD_BITS = 32,
  parameter int INDEX_BITS = 16,
  parameter int ACC_BITS   = 48
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  tnga_node_if.sink  node_i,
  tnga_res_if.source res_o,
  tnga_cfg_if.sink   cfg_i
);

  // datapath widths
  localparam int MAG_W  = COORD_BITS + 1;               // |c - p|
  localparam int SQ_W   = 2 * MAG_W;
  localparam int D2_W   = SQ_W + 2;                     // sum of three squares
  localparam int MA_W   = (D2_W > tnga_pkg::ROOT_W) ? D2_W : tnga_pkg::ROOT_W;
  localparam int MB_W   = tnga_pkg::ROOT_W;
  localparam int P_W    = MA_W + MB_W;
  localparam int LHS_W  = 2 * tnga_pkg::SIDE_W + tnga_pkg::LHS_SHIFT;
  localparam int RHS_W  = D2_W + tnga_pkg::REG_W;
  localparam int CMP_W  = (LHS_W > RHS_W) ? LHS_W : RHS_W;
  localparam int RS_W   = ((D2_W > 48) ? D2_W : 48) + 1;
  localparam int RX_W   = (RS_W > tnga_pkg::ROOT_W + 1) ? RS_W : tnga_pkg::ROOT_W + 1;
  localparam int NUMP_W = tnga_pkg::FM_W + MAG_W;
  localparam int NUM_W  = NUMP_W + tnga_pkg::NUM_SHIFT;
  localparam int Q_W    = ACC_BITS - 1;

  // sequencer
  tnga_pkg::tnga_state_e state_q, state_d;
  logic [1:0]            ax_q;
  logic                  accept;

  // registers
  logic [tnga_pkg::REG_W-1:0] theta_q, grav_q, soft_q;
  logic [COORD_BITS-1:0]      px_q, py_q, pz_q;
  logic [INDEX_BITS-1:0]      self_q;

  // node held while it is worked on
  logic [tnga_pkg::KIND_W-1:0] kind_q;
  logic [INDEX_BITS-1:0]       part_q;
  logic [tnga_pkg::REG_W-1:0]  mass_q;
  logic [tnga_pkg::SIDE_W-1:0] side_q;
  logic [MAG_W-1:0]            dmag_q [tnga_pkg::AXES];
  logic                        dneg_q [tnga_pkg::AXES];
  logic [D2_W-1:0]             d2_q;
  logic [LHS_W-1:0]            lhs_q;
  logic [tnga_pkg::ROOT_W-1:0] r_q;
  logic [tnga_pkg::DEN_W-1:0]  den_q;
  logic [tnga_pkg::FM_W-1:0]   fm_q;
  logic                        descend_q;

  // accumulators and result stage
  logic [ACC_BITS-1:0] acc_q [tnga_pkg::AXES];
  logic                out_valid_q;
  logic                out_descend_q;
  logic [ACC_BITS-1:0] out_x_q, out_y_q, out_z_q;

  // shared units
  logic                        mul_start, mul_done;
  logic [MA_W-1:0]             mul_a;
  logic [MB_W-1:0]             mul_b;
  logic [P_W-1:0]              mul_prod;
  logic                        root_start, root_done;
  logic [tnga_pkg::ROOT_W-1:0] root;
  logic                        div_start, div_done;
  logic [NUM_W-1:0]            div_num;
  logic [Q_W-1:0]              quot;

  // combinational helpers
  logic [COORD_BITS-1:0] cen  [tnga_pkg::AXES];
  logic [COORD_BITS-1:0] pos  [tnga_pkg::AXES];
  logic [MAG_W-1:0]      dc   [tnga_pkg::AXES];
  logic                  far_enough;
  logic [RX_W-1:0]       rsum;
  logic [tnga_pkg::ROOT_W-1:0] r_sat;
  logic [ACC_BITS-1:0]   contrib;
  logic [ACC_BITS:0]     acc_sum;
  logic [ACC_BITS-1:0]   acc_next;

  assign accept      = node_i.valid && node_i.ready;
  assign node_i.ready = (state_q == tnga_pkg::ST_IDLE);
  assign cfg_i.ready = 1'b1;

  assign res_o.valid     = out_valid_q;
  assign res_o.descend   = out_descend_q;
  assign res_o.sum_acc_x = out_x_q;
  assign res_o.sum_acc_y = out_y_q;
  assign res_o.sum_acc_z = out_z_q;

  // offsets from the particle, kept as sign and magnitude
  assign cen[0] = node_i.centre_x;
  assign cen[1] = node_i.centre_y;
  assign cen[2] = node_i.centre_z;
  assign pos[0] = px_q;
  assign pos[1] = py_q;
  assign pos[2] = pz_q;

  always_comb begin
    for (int i = 0; i < tnga_pkg::AXES; i++) begin
      dc[i] = {cen[i][COORD_BITS-1], cen[i]} - {pos[i][COORD_BITS-1], pos[i]};
    end
  end

  // opening test side^2 * 2^16 < theta^2 * d^2, product still in the multiplier
  assign far_enough = CMP_W'(lhs_q) < CMP_W'(mul_prod[RHS_W-1:0]);

  // softened radius sum, clipped to 64 bits
  assign rsum  = RX_W'(d2_q) + RX_W'({soft_q, {tnga_pkg::LHS_SHIFT{1'b0}}});
  assign r_sat = (|rsum[RX_W-1:tnga_pkg::ROOT_W]) ? '1 : rsum[tnga_pkg::ROOT_W-1:0];

  // numerator G*m*|d| * 2^56 comes straight from the multiplier
  assign div_num = {mul_prod[NUMP_W-1:0], {tnga_pkg::NUM_SHIFT{1'b0}}};

  // signed saturating add of one axis term
  always_comb begin
    contrib  = dneg_q[ax_q] ? (ACC_BITS'(0) - {1'b0, quot}) : {1'b0, quot};
    acc_sum  = {acc_q[ax_q][ACC_BITS-1], acc_q[ax_q]} + {contrib[ACC_BITS-1], contrib};
    acc_next = acc_sum[ACC_BITS-1:0];
    if (acc_sum[ACC_BITS] != acc_sum[ACC_BITS-1]) begin
      acc_next = acc_sum[ACC_BITS] ? {1'b1, {(ACC_BITS-1){1'b0}}}
                                   : {1'b0, {(ACC_BITS-1){1'b1}}};
    end
  end

  // next state and unit controls
  always_comb begin
    state_d    = state_q;
    mul_start  = 1'b0;
    root_start = 1'b0;
    div_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state_q)
      tnga_pkg::ST_IDLE: begin
        if (node_i.valid) state_d = tnga_pkg::ST_SQ_GO;
      end
      tnga_pkg::ST_SQ_GO: begin
        mul_start = 1'b1;
        mul_a     = MA_W'(dmag_q[ax_q]);
        mul_b     = MB_W'(dmag_q[ax_q]);
        state_d   = tnga_pkg::ST_SQ_WAIT;
      end
      tnga_pkg::ST_SQ_WAIT: begin
        if (mul_done) begin
          state_d = (ax_q == tnga_pkg::LAST_AXIS) ? tnga_pkg::ST_KIND : tnga_pkg::ST_SQ_GO;
        end
      end
      tnga_pkg::ST_KIND: begin
        priority if (kind_q == tnga_pkg::KIND_INTERNAL) begin
          state_d = tnga_pkg::ST_LHS_GO;
        end else if (kind_q == tnga_pkg::KIND_EXTERNAL && part_q != self_q) begin
          state_d = tnga_pkg::ST_RSUM;
        end else begin
          state_d = tnga_pkg::ST_OUT;
        end
      end
      tnga_pkg::ST_LHS_GO: begin
        mul_start = 1'b1;
        mul_a     = MA_W'(side_q);
        mul_b     = MB_W'(side_q);
        state_d   = tnga_pkg::ST_LHS_WAIT;
      end
      tnga_pkg::ST_LHS_WAIT: begin
        if (mul_done) state_d = tnga_pkg::ST_RHS_GO;
      end
      tnga_pkg::ST_RHS_GO: begin
        mul_start = 1'b1;
        mul_a     = MA_W'(d2_q);
        mul_b     = MB_W'(theta_q);
        state_d   = tnga_pkg::ST_RHS_WAIT;
      end
      tnga_pkg::ST_RHS_WAIT: begin
        if (mul_done) state_d = far_enough ? tnga_pkg::ST_RSUM : tnga_pkg::ST_OUT;
      end
      tnga_pkg::ST_RSUM: begin
        // zero distance with zero softening adds nothing
        state_d = (r_sat == '0) ? tnga_pkg::ST_OUT : tnga_pkg::ST_ROOT_GO;
      end
      tnga_pkg::ST_ROOT_GO: begin
        root_start = 1'b1;
        state_d    = tnga_pkg::ST_ROOT_WAIT;
      end
      tnga_pkg::ST_ROOT_WAIT: begin
        if (root_done) state_d = tnga_pkg::ST_DEN_GO;
      end
      tnga_pkg::ST_DEN_GO: begin
        mul_start = 1'b1;
        mul_a     = MA_W'(r_q);
        mul_b     = root;
        state_d   = tnga_pkg::ST_DEN_WAIT;
      end
      tnga_pkg::ST_DEN_WAIT: begin
        if (mul_done) state_d = tnga_pkg::ST_FM_GO;
      end
      tnga_pkg::ST_FM_GO: begin
        mul_start = 1'b1;
        mul_a     = MA_W'(grav_q);
        mul_b     = MB_W'(mass_q);
        state_d   = tnga_pkg::ST_FM_WAIT;
      end
      tnga_pkg::ST_FM_WAIT: begin
        if (mul_done) state_d = tnga_pkg::ST_NUM_GO;
      end
      tnga_pkg::ST_NUM_GO: begin
        mul_start = 1'b1;
        mul_a     = MA_W'(fm_q);
        mul_b     = MB_W'(dmag_q[ax_q]);
        state_d   = tnga_pkg::ST_NUM_WAIT;
      end
      tnga_pkg::ST_NUM_WAIT: begin
        if (mul_done) state_d = tnga_pkg::ST_DIV_GO;
      end
      tnga_pkg::ST_DIV_GO: begin
        div_start = 1'b1;
        state_d   = tnga_pkg::ST_DIV_WAIT;
      end
      tnga_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          state_d = (ax_q == tnga_pkg::LAST_AXIS) ? tnga_pkg::ST_OUT : tnga_pkg::ST_NUM_GO;
        end
      end
      tnga_pkg::ST_OUT: begin
        // result stage must be free or draining this cycle
        if (!out_valid_q || res_o.ready) state_d = tnga_pkg::ST_IDLE;
      end
      default: state_d = tnga_pkg::ST_IDLE;
    endcase
  end

  // control state, registers and accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tnga_pkg::ST_IDLE;
      ax_q        <= '0;
      out_valid_q <= 1'b0;
      theta_q     <= tnga_pkg::THETA_RST;
      grav_q      <= tnga_pkg::GRAV_RST;
      soft_q      <= tnga_pkg::SOFT_RST;
      px_q        <= '0;
      py_q        <= '0;
      pz_q        <= '0;
      self_q      <= '0;
      for (int i = 0; i < tnga_pkg::AXES; i++) acc_q[i] <= '0;
    end else begin
      state_q <= state_d;

      // axis counter walks the squares, then the per-axis divides
      if (accept) begin
        ax_q <= '0;
      end else if ((state_q == tnga_pkg::ST_SQ_WAIT && mul_done) ||
                   (state_q == tnga_pkg::ST_DIV_WAIT && div_done)) begin
        ax_q <= (ax_q == tnga_pkg::LAST_AXIS) ? 2'd0 : ax_q + 2'd1;
      end

      if (state_q == tnga_pkg::ST_OUT && state_d == tnga_pkg::ST_IDLE) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end

      if (accept && node_i.start_walk) begin
        for (int i = 0; i < tnga_pkg::AXES; i++) acc_q[i] <= '0;
      end else if (state_q == tnga_pkg::ST_DIV_WAIT && div_done) begin
        acc_q[ax_q] <= acc_next;
      end

      if (cfg_i.valid && cfg_i.ready) begin
        unique case (cfg_i.index)
          tnga_pkg::REG_THETA: theta_q <= cfg_i.data[tnga_pkg::REG_W-1:0];
          tnga_pkg::REG_GRAV:  grav_q  <= cfg_i.data[tnga_pkg::REG_W-1:0];
          tnga_pkg::REG_SOFT:  soft_q  <= cfg_i.data[tnga_pkg::REG_W-1:0];
          tnga_pkg::REG_PX:    px_q    <= cfg_i.data[COORD_BITS-1:0];
          tnga_pkg::REG_PY:    py_q    <= cfg_i.data[COORD_BITS-1:0];
          tnga_pkg::REG_PZ:    pz_q    <= cfg_i.data[COORD_BITS-1:0];
          tnga_pkg::REG_SELF:  self_q  <= cfg_i.data[INDEX_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  // node payload and intermediate results
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q    <= node_i.node_kind;
      part_q    <= node_i.node_particle;
      mass_q    <= node_i.node_mass;
      side_q    <= node_i.node_side;
      d2_q      <= '0;
      descend_q <= 1'b1;
      for (int i = 0; i < tnga_pkg::AXES; i++) begin
        dneg_q[i] <= dc[i][MAG_W-1];
        dmag_q[i] <= dc[i][MAG_W-1] ? (MAG_W'(0) - dc[i]) : dc[i];
      end
    end
    if (state_q == tnga_pkg::ST_SQ_WAIT && mul_done) begin
      d2_q <= d2_q + D2_W'(mul_prod[SQ_W-1:0]);
    end
    if (state_q == tnga_pkg::ST_LHS_WAIT && mul_done) begin
      lhs_q <= {mul_prod[2*tnga_pkg::SIDE_W-1:0], {tnga_pkg::LHS_SHIFT{1'b0}}};
    end
    if (state_q == tnga_pkg::ST_RHS_WAIT && mul_done && far_enough) begin
      descend_q <= 1'b0;
    end
    if (state_q == tnga_pkg::ST_RSUM) begin
      r_q <= r_sat;
    end
    if (state_q == tnga_pkg::ST_DEN_WAIT && mul_done) begin
      den_q <= mul_prod[tnga_pkg::DEN_W-1:0];
    end
    if (state_q == tnga_pkg::ST_FM_WAIT && mul_done) begin
      fm_q <= mul_prod[tnga_pkg::FM_W-1:0];
    end
    if (state_q == tnga_pkg::ST_OUT && state_d == tnga_pkg::ST_IDLE) begin
      out_descend_q <= descend_q;
      out_x_q       <= acc_q[0];
      out_y_q       <= acc_q[1];
      out_z_q       <= acc_q[2];
    end
  end

  tnga_mul #(
    .A_W (MA_W),
    .B_W (MB_W)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  tnga_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_start),
    .r_i     (r_q),
    .done_o  (root_done),
    .root_o  (root)
  );

  tnga_div #(
    .NUM_W (NUM_W),
    .DEN_W (tnga_pkg::DEN_W),
    .Q_W   (Q_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (den_q),
    .done_o  (div_done),
    .quot_o  (quot)
  );

endmodule

### bench/tb_tree_node_gravity_accumulate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tree node gravity accumulator testbench
// Feeds node items through the handshake, predicts the opening decision and
// the softened acceleration sums in exact integer arithmetic, and compares
// every result field by field with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_tree_node_gravity_accumulate;

  localparam int COORD_BITS = 32;
  localparam int INDEX_BITS = 16;
  localparam int ACC_BITS   = 48;

  typedef struct packed {
    logic                  start_walk;
    logic [1:0]            node_kind;
    logic [INDEX_BITS-1:0] node_particle;
    logic [31:0]           node_mass;
    logic [31:0]           centre_x;
    logic [31:0]           centre_y;
    logic [31:0]           centre_z;
    logic [30:0]           node_side;
  } node_t;

  typedef struct packed {
    logic                descend;
    logic [ACC_BITS-1:0] acc_x;
    logic [ACC_BITS-1:0] acc_y;
    logic [ACC_BITS-1:0] acc_z;
  } accel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tnga_node_if #(COORD_BITS, INDEX_BITS) node_ch ();
  tnga_res_if #(ACC_BITS) res_ch ();
  tnga_cfg_if #(32) cfg_ch ();

  tree_node_gravity_accumulate #(
    .COORD_BITS(COORD_BITS), .INDEX_BITS(INDEX_BITS), .ACC_BITS(ACC_BITS)
  ) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .node_i(node_ch.sink),
    .res_o(res_ch.source), .cfg_i(cfg_ch.sink)
  );

  always #5 clk_i = ~clk_i;

  // predictor copy of the registers and accumulators
  logic [31:0] theta_sq, grav_g, soft_sq;
  logic signed [63:0] pos_x, pos_y, pos_z;
  logic [INDEX_BITS-1:0] own_index;
  logic signed [63:0] sum_x, sum_y, sum_z;

  accel_t accel_queue[$];
  int fail_count = 0;
  int hold_off = 0;        // forced long receiver stall, in cycles
  bit sink_busy_mode = 1'b0;

  task automatic report(input string what, input logic [63:0] got,
                        input logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic logic [63:0] abs64(input logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  // floor(fm * |d| * 2^56 / den), saturated to the accumulator limit
  function automatic logic signed [63:0] axis_accel(input logic [63:0] fm,
      input logic signed [63:0] d, input logic [191:0] den);
    logic [191:0] num;
    logic [191:0] q;
    logic [63:0] top;
    top = 64'd1 << (ACC_BITS - 1);
    if (d == 0) return 0;
    num = ({128'd0, fm} * {128'd0, abs64(d)}) << 56;
    q = num / den;
    if (q >= top) q = top - 1;
    return d < 0 ? -$signed(q[63:0]) : $signed(q[63:0]);
  endfunction

  function automatic logic signed [63:0] sat_sum(input logic signed [63:0] a,
                                                 input logic signed [63:0] c);
    logic signed [63:0] hi, lo, s;
    hi = (64'sd1 <<< (ACC_BITS - 1)) - 1;
    lo = -hi - 1;
    s = a + c;
    if (s > hi) return hi;
    if (s < lo) return lo;
    return s;
  endfunction

  task automatic add_pull(input logic [31:0] mass, input logic signed [63:0] dx,
                          input logic signed [63:0] dy, input logic signed [63:0] dz,
                          input logic [191:0] d2);
    logic [191:0] rsum, sq;
    logic [63:0] r, s, b;
    logic [191:0] den;
    logic [63:0] fm;
    int i;
    rsum = d2 + ({160'd0, soft_sq} << 16);
    r = (rsum[191:64] != 0) ? '1 : rsum[63:0];
    if (r == 0) return;
    s = 0;
    for (i = 63; i >= 0; i--) begin
      b = s | (64'd1 << i);
      sq = {64'd0, b} * {128'd0, b};
      if (sq <= {64'd0, r, 64'd0}) s = b;
    end
    den = {128'd0, r} * {128'd0, s};
    fm = grav_g * mass;
    sum_x = sat_sum(sum_x, axis_accel(fm, dx, den));
    sum_y = sat_sum(sum_y, axis_accel(fm, dy, den));
    sum_z = sat_sum(sum_z, axis_accel(fm, dz, den));
  endtask

  task automatic predict_node(input node_t n);
    logic signed [63:0] dx, dy, dz;
    logic [191:0] d2, lhs, rhs;
    accel_t e;
    dx = $signed(n.centre_x) - pos_x;
    dy = $signed(n.centre_y) - pos_y;
    dz = $signed(n.centre_z) - pos_z;
    d2 = {128'd0, abs64(dx)} * {128'd0, abs64(dx)} + {128'd0, abs64(dy)} * abs64(dy)
       + {128'd0, abs64(dz)} * abs64(dz);
    e.descend = 1'b1;
    if (n.start_walk) begin
      sum_x = 0; sum_y = 0; sum_z = 0;
    end
    if (n.node_kind == tnga_pkg::KIND_INTERNAL) begin
      lhs = ({161'd0, n.node_side} * {161'd0, n.node_side}) << 16;
      rhs = d2 * {160'd0, theta_sq};
      if (lhs < rhs) begin
        add_pull(n.node_mass, dx, dy, dz, d2);
        e.descend = 1'b0;
      end
    end else if (n.node_kind == tnga_pkg::KIND_EXTERNAL && n.node_particle != own_index) begin
      add_pull(n.node_mass, dx, dy, dz, d2);
    end
    e.acc_x = sum_x[ACC_BITS-1:0];
    e.acc_y = sum_y[ACC_BITS-1:0];
    e.acc_z = sum_z[ACC_BITS-1:0];
    accel_queue.push_back(e);
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_node(input node_t n);
    int g;
    g = gap_len();
    // valid drops between items
    repeat (g + 1) @(posedge clk_i);
    node_ch.valid <= 1'b1;
    {node_ch.start_walk, node_ch.node_kind, node_ch.node_particle, node_ch.node_mass,
     node_ch.centre_x, node_ch.centre_y, node_ch.centre_z, node_ch.node_side} <= n;
    do @(posedge clk_i); while (!node_ch.ready);
    predict_node(n);
    node_ch.valid <= 1'b0;
  endtask

  task automatic write_reg(input tnga_pkg::cfg_reg_e idx, input logic [31:0] value);
    @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      tnga_pkg::REG_THETA: theta_sq = value;
      tnga_pkg::REG_GRAV:  grav_g = value;
      tnga_pkg::REG_SOFT:  soft_sq = value;
      tnga_pkg::REG_PX:    pos_x = $signed(value);
      tnga_pkg::REG_PY:    pos_y = $signed(value);
      tnga_pkg::REG_PZ:    pos_z = $signed(value);
      tnga_pkg::REG_SELF:  own_index = value[INDEX_BITS-1:0];
      default: ;
    endcase
  endtask

  // drain all expected results, then let the block settle before a write
  task automatic settle();
    while (accel_queue.size() != 0) @(posedge clk_i);
    repeat (700) @(posedge clk_i);
  endtask

  // sink side: random ready in busy mode, else always ready, with a forced long hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      res_ch.ready <= 1'b0;
    end else if (sink_busy_mode) begin
      res_ch.ready <= ($urandom_range(0, 99) < 60);
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    accel_t e;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (accel_queue.size() == 0) begin
        report("unexpected item", 0, 0);
      end else begin
        e = accel_queue.pop_front();
        if (res_ch.descend !== e.descend) report("descend", res_ch.descend, e.descend);
        if (res_ch.sum_acc_x !== e.acc_x) report("sum_acc_x", res_ch.sum_acc_x, e.acc_x);
        if (res_ch.sum_acc_y !== e.acc_y) report("sum_acc_y", res_ch.sum_acc_y, e.acc_y);
        if (res_ch.sum_acc_z !== e.acc_z) report("sum_acc_z", res_ch.sum_acc_z, e.acc_z);
      end
    end
  end

  function automatic logic [31:0] near_coord(input logic signed [31:0] base, int span);
    return base + $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic node_t rand_node(input bit walk_first);
    node_t n;
    int p;
    n.start_walk = walk_first ? 1'b1 : ($urandom_range(0, 19) == 0);
    p = $urandom_range(0, 99);
    n.node_kind = p < 45 ? tnga_pkg::KIND_INTERNAL : p < 85 ? tnga_pkg::KIND_EXTERNAL :
                  p < 95 ? tnga_pkg::KIND_UNUSED : 2'd3;
    n.node_particle = $urandom_range(0, 7) == 0 ? own_index : INDEX_BITS'($urandom);
    n.node_mass = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0010_0000);
    if ($urandom_range(0, 4) == 0) begin
      n.centre_x = $urandom; n.centre_y = $urandom; n.centre_z = $urandom;
      n.node_side = 31'($urandom);
    end else begin
      n.centre_x = near_coord(pos_x[31:0], 32'h0040_0000);
      n.centre_y = near_coord(pos_y[31:0], 32'h0040_0000);
      n.centre_z = near_coord(pos_z[31:0], 32'h0040_0000);
      n.node_side = 31'($urandom_range(0, 32'h0080_0000));
    end
    return n;
  endfunction

  function automatic node_t make_node(input logic sw, input logic [1:0] k,
      input logic [15:0] pi, input logic [31:0] m, input logic [31:0] x,
      input logic [31:0] y, input logic [31:0] z, input logic [30:0] l);
    node_t n;
    n = '{sw, k, pi, m, x, y, z, l};
    return n;
  endfunction

  task automatic test_directed();
    send_node(make_node(1, tnga_pkg::KIND_INTERNAL, 0, 32'h10000, 32'h10000, 0, 0, 1));
    send_node(make_node(0, tnga_pkg::KIND_INTERNAL, 0, 32'h10000, 0, 0, 0, 0)); // zero distance
    send_node(make_node(0, tnga_pkg::KIND_UNUSED, 5, '1, 32'h7fffffff, 0, 0, 0));
    send_node(make_node(0, 2'd3, 5, '1, 32'h80000000, 0, 0, 0));       // kind three
    send_node(make_node(0, tnga_pkg::KIND_EXTERNAL, 0, '1, 32'h20000, 0, 0, 0)); // self particle
    send_node(make_node(0, tnga_pkg::KIND_EXTERNAL, 16'hffff, '1, 32'h10000, 32'h10000,
                        0, '1));
    send_node(make_node(0, tnga_pkg::KIND_EXTERNAL, 1, '1, 32'h7fffffff, 32'h80000000,
                        32'h7fffffff, '1));
    send_node(make_node(0, tnga_pkg::KIND_INTERNAL, 2, '1, 32'h80000000, 32'h80000000,
                        32'h80000000, 0));
    send_node(make_node(0, tnga_pkg::KIND_INTERNAL, 2, '1, 32'h7fffffff, 32'h7fffffff,
                        32'h7fffffff, '1));
    send_node(make_node(1, tnga_pkg::KIND_EXTERNAL, 3, 0, 1, 0, 0, 0));
    send_node(make_node(0, tnga_pkg::KIND_EXTERNAL, 3, '1, 0, 0, 1, 0)); // coincident axes
    settle();
    // zero distance and zero softening
    write_reg(tnga_pkg::REG_SOFT, 0);
    send_node(make_node(1, tnga_pkg::KIND_EXTERNAL, 9, 32'h10000, 0, 0, 0, 0));
    send_node(make_node(0, tnga_pkg::KIND_EXTERNAL, 9, 32'h10000, 1, 1, 1, 0));
    settle();
  endtask

  task automatic test_config_extremes();
    write_reg(tnga_pkg::REG_THETA, '1);
    write_reg(tnga_pkg::REG_GRAV, '1);
    write_reg(tnga_pkg::REG_SOFT, '1);
    write_reg(tnga_pkg::REG_PX, 32'h80000000);
    write_reg(tnga_pkg::REG_PY, 32'h7fffffff);
    write_reg(tnga_pkg::REG_PZ, 0);
    write_reg(tnga_pkg::REG_SELF, 16'hffff);
    send_node(make_node(1, tnga_pkg::KIND_INTERNAL, 0, '1, 32'h7fffffff, 32'h80000000, 0, 1));
    send_node(make_node(0, tnga_pkg::KIND_EXTERNAL, 16'hffff, '1, 0, 0, 0, 0));
    send_node(make_node(0, tnga_pkg::KIND_EXTERNAL, 0, '1, 32'h7fffffff, 32'h80000000,
                        32'h7fffffff, 0));
    settle();
    write_reg(tnga_pkg::REG_THETA, 0);
    write_reg(tnga_pkg::REG_GRAV, 0);
    write_reg(tnga_pkg::REG_SELF, 0);
    send_node(make_node(1, tnga_pkg::KIND_INTERNAL, 0, '1, 0, 0, 0, 0));
    send_node(make_node(0, tnga_pkg::KIND_EXTERNAL, 1, '1, 5, 5, 5, 0));
    settle();
  endtask

  // random phases over a handful of register settings
  task automatic test_random_walks(input int count);
    int i;
    sink_busy_mode = 1'b1;
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(tnga_pkg::REG_THETA,
                ph == 0 ? 32'd16384 : ph == 4 ? '1 : $urandom_range(0, 32'h40000));
      write_reg(tnga_pkg::REG_GRAV, ph == 4 ? '1 : $urandom_range(0, 32'h40000));
      write_reg(tnga_pkg::REG_SOFT, ph == 3 ? 0 : $urandom_range(0, 32'h20000));
      write_reg(tnga_pkg::REG_PX, $urandom);
      write_reg(tnga_pkg::REG_PY, $urandom);
      write_reg(tnga_pkg::REG_PZ, $urandom);
      write_reg(tnga_pkg::REG_SELF, $urandom);
      for (i = 0; i < count / 5; i++) send_node(rand_node(i == 0));
      settle();
    end
  endtask

  // the receiver stalls while nodes keep coming, so the input backs up
  task automatic test_backpressure();
    int i;
    hold_off = 3000;
    for (i = 0; i < 20; i++) send_node(rand_node(i == 0));
    settle();
  endtask

  initial begin
    node_ch.valid = 1'b0;
    node_ch.start_walk = 1'b0;
    node_ch.node_kind = tnga_pkg::KIND_INTERNAL;
    node_ch.node_particle = '0;
    node_ch.node_mass = '0;
    node_ch.centre_x = '0;
    node_ch.centre_y = '0;
    node_ch.centre_z = '0;
    node_ch.node_side = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = tnga_pkg::REG_THETA;
    cfg_ch.data = '0;
    theta_sq = tnga_pkg::THETA_RST; grav_g = tnga_pkg::GRAV_RST; soft_sq = tnga_pkg::SOFT_RST;
    pos_x = 0; pos_y = 0; pos_z = 0; own_index = 0;
    sum_x = 0; sum_y = 0; sum_z = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_extremes();
    test_backpressure();
    test_random_walks(1000);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #(10 * 5000 * 1000);
    $display("Test completed with failures");
    $finish;
  end

endmodule

### filelist.f
design/tnga_pkg.sv
design/tnga_if.sv
design/tnga_mul.sv
design/tnga_sqrt.sv
design/tnga_div.sv
design/tree_node_gravity_accumulate.sv
bench/tb_tree_node_gravity_accumulate.sv
